/* sv/gspid_pkg.sv */
// ----------------------------------------------------------------------------
// gspid_pkg
// Shared widths, codes, gain table and divider handshake types for the
// gain-scheduled incremental PID core.
// ----------------------------------------------------------------------------
package gspid_pkg;

  // Default sample width of setpoint and measurement
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field and register widths
  localparam int DIV_W      = 17;
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int INTEG_W    = 14;
  localparam int STEP_W     = 8;
  localparam int BAND_W     = 2;
  localparam int GAIN_W     = 6;
  localparam int TERM_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEGACY  = 2'd2;

  // Command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Gain bands
  localparam logic [BAND_W-1:0] BAND_SMALL  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MEDIUM = 2'd1;
  localparam logic [BAND_W-1:0] BAND_LARGE  = 2'd2;

  // Terms accumulated by the shared multiply-add step
  localparam logic [TERM_W-1:0] TERM_P = 2'd0;
  localparam logic [TERM_W-1:0] TERM_I = 2'd1;
  localparam logic [TERM_W-1:0] TERM_D = 2'd2;

  // Band thresholds: 50/25 and 300/25 periods, measurement above 500/25
  localparam int BAND_SMALL_LIM  = 50 / 25;
  localparam int BAND_MEDIUM_LIM = 300 / 25;
  localparam int MEAS_BAND_MIN   = 500 / 25;

  // Saturation limits
  localparam int INTEG_LIMIT = 5000;
  localparam int STEP_LIMIT  = 100;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Hard-wired gain schedule for both control laws
  function automatic gains_t gspid_gains(input logic legacy, input logic [BAND_W-1:0] band);
    gains_t g;
    g = '0;
    if (legacy) begin
      case (band)
        BAND_SMALL:  g = '{kp: 6'd0,  ki: 6'd0, kd: 6'd50};
        BAND_MEDIUM: g = '{kp: 6'd5,  ki: 6'd5, kd: 6'd30};
        default:     g = '{kp: 6'd10, ki: 6'd5, kd: 6'd0};
      endcase
    end else begin
      case (band)
        BAND_SMALL:  g = '{kp: 6'd5, ki: 6'd5,  kd: 6'd10};
        BAND_MEDIUM: g = '{kp: 6'd5, ki: 6'd5,  kd: 6'd5};
        default:     g = '{kp: 6'd5, ki: 6'd15, kd: 6'd0};
      endcase
    end
    return g;
  endfunction

endpackage

/* sv/gspid_in_if.sv */
// ----------------------------------------------------------------------------
// gspid_in_if
// Input channel: command, setpoint and measurement with valid/ready.
// ----------------------------------------------------------------------------
interface gspid_in_if #(
  parameter int SAMPLE_WIDTH = gspid_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output cmd, output setpoint, output measured, input ready);
  modport sink   (input valid, input cmd, input setpoint, input measured, output ready);
endinterface

/* sv/gspid_out_if.sv */
// ----------------------------------------------------------------------------
// gspid_out_if
// Result channel: clamped drive step and gain band with valid/ready.
// ----------------------------------------------------------------------------
interface gspid_out_if;
  import gspid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [STEP_W-1:0] drive_step;
  logic [BAND_W-1:0]        gain_band;

  modport source (output valid, output drive_step, output gain_band, input ready);
  modport sink   (input valid, input drive_step, input gain_band, output ready);
endinterface

/* sv/gspid_divider.sv */
// ----------------------------------------------------------------------------
// gspid_divider
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module gspid_divider #(
  parameter int DVD_W = 27
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gspid_pkg::div_ctrl_t         ctrl_i,
  input  logic [DVD_W-1:0]             dividend_i,
  input  logic [gspid_pkg::DIV_W-1:0]  divisor_i,
  output gspid_pkg::div_stat_t         stat_o,
  output logic [DVD_W-1:0]             quot_o
);
  import gspid_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] dsr_q;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] trial;
  logic             qbit;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign qbit   = ~trial[DIV_W+1];

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Flag completion for one cycle after the last quotient bit
      done_q <= busy_q && !ctrl_i.start && (cnt_q == CNT_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], qbit};
      rem_q <= qbit ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

/* sv/gain_scheduled_incremental_pid_core.sv */
// An accepted compute transaction passes the band, integral, multiply-add, divider
// start, division and output states; a clear transaction gives no result.
// Input is accepted only in idle, so a new transaction waits for the output load and the
// serial divider, which retires one quotient bit per cycle over the full sum width.
// Reset: asynchronous active low; divisor and period reset to 1, law to new, history zero.
// ----------------------------------------------------------------------------
// gain_scheduled_incremental_pid_core
// Gain-scheduled incremental PID step: band selection, legacy integral, three-term shared
// multiply-add, serial division by the output divisor and output clamp.
// ----------------------------------------------------------------------------
module gain_scheduled_incremental_pid_core #(
  parameter int SAMPLE_WIDTH = gspid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gspid_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gspid_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  gspid_in_if.sink                          item_i,
  gspid_out_if.source                       result_o
);
  import gspid_pkg::*;

  localparam int EW     = SAMPLE_WIDTH + 1;
  localparam int OP_W   = (SAMPLE_WIDTH + 3 > INTEG_W) ? SAMPLE_WIDTH + 3 : INTEG_W;
  localparam int PROD_W = OP_W + GAIN_W + 1;
  localparam int SUM_W  = OP_W + 8;
  localparam int CMP_W  = (EW > PER_W + 4) ? EW : PER_W + 4;
  localparam int IS_W   = ((EW > INTEG_W) ? EW : INTEG_W) + 1;

  localparam logic signed [SAMPLE_WIDTH-1:0] MS_MIN    = SAMPLE_WIDTH'(MEAS_BAND_MIN);
  localparam logic signed [IS_W-1:0]         ILIM      = IS_W'(INTEG_LIMIT);
  localparam logic signed [INTEG_W-1:0]      ILIM_CHK  = INTEG_W'(INTEG_LIMIT);
  localparam logic signed [STEP_W-1:0]       SLIM      = STEP_W'(STEP_LIMIT);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BAND  = 3'd1;
  localparam logic [2:0] ST_INTEG = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [DIV_W-1:0] div_q;
  logic [PER_W-1:0] per_q;
  logic             legacy_q;

  // Loop history and working registers
  logic signed [EW-1:0]      e_q;
  logic signed [EW-1:0]      e1_q;
  logic signed [EW-1:0]      e2_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic                      ms_gt_q;
  logic [BAND_W-1:0]         band_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic [TERM_W-1:0]         term_q;

  // Output register
  logic                      out_valid_q;
  logic signed [STEP_W-1:0]  out_step_q;
  logic [BAND_W-1:0]         out_band_q;

  logic in_fire;
  logic out_load;

  // Write configuration registers; zero divisor and period act as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= DIV_W'(1);
      per_q    <= PER_W'(1);
      legacy_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUT_DIV: div_q <= (cfg_data_i == '0) ? DIV_W'(1) : cfg_data_i[DIV_W-1:0];
        REG_PERIOD:  per_q <= (cfg_data_i[PER_W-1:0] == '0) ? PER_W'(1)
                                                            : cfg_data_i[PER_W-1:0];
        REG_LEGACY:  legacy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;

  // Error at acceptance
  logic signed [EW-1:0] e_new;
  assign e_new = EW'(item_i.setpoint) - EW'(item_i.measured);

  // Band choice: q < k  is  |e| < k * period
  logic [EW-1:0]    mag;
  logic [CMP_W-1:0] mag_x, lim_small, lim_medium;
  logic [BAND_W-1:0] band_d;
  assign mag        = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
  assign mag_x      = CMP_W'(mag);
  assign lim_small  = CMP_W'(per_q) * CMP_W'(BAND_SMALL_LIM);
  assign lim_medium = CMP_W'(per_q) * CMP_W'(BAND_MEDIUM_LIM);

  always_comb begin
    if (mag_x < lim_small) begin
      band_d = BAND_SMALL;
    end else if (mag_x < lim_medium && (legacy_q || ms_gt_q)) begin
      band_d = BAND_MEDIUM;
    end else begin
      band_d = BAND_LARGE;
    end
  end

  // Legacy integral: restart from zero in small band, add error, saturate
  logic signed [IS_W-1:0]    integ_base, integ_sum;
  logic signed [INTEG_W-1:0] integ_d;
  assign integ_base = (band_q == BAND_SMALL) ? '0 : IS_W'(integ_q);
  assign integ_sum  = integ_base + IS_W'(e_q);

  always_comb begin
    if (integ_sum > ILIM) begin
      integ_d = INTEG_W'(ILIM);
    end else if (integ_sum < -ILIM) begin
      integ_d = INTEG_W'(-ILIM);
    end else begin
      integ_d = INTEG_W'(integ_sum);
    end
  end

  // Shared multiply-add: one gain term per cycle
  gains_t                   gains;
  logic signed [OP_W-1:0]   d1, d2, op;
  logic [GAIN_W-1:0]        gain;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc_d;

  assign gains = gspid_gains(legacy_q, band_q);
  assign d1    = OP_W'(e_q) - OP_W'(e1_q);
  assign d2    = d1 - OP_W'(e1_q) + OP_W'(e2_q);

  always_comb begin
    case (term_q)
      TERM_P: begin
        op   = d1;
        gain = gains.kp;
      end
      TERM_I: begin
        op   = legacy_q ? OP_W'(integ_q) : OP_W'(e_q);
        gain = gains.ki;
      end
      default: begin
        op   = legacy_q ? d1 : d2;
        gain = gains.kd;
      end
    endcase
  end

  assign gain_s = $signed({1'b0, gain});
  assign prod   = PROD_W'(op * gain_s);
  assign acc_d  = acc_q + SUM_W'(prod);

  // Serial division of the sum magnitude
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [SUM_W-1:0] dvd_mag;
  logic [SUM_W-1:0] quot;

  assign div_ctrl.start = (state_q == ST_START);
  assign dvd_mag        = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);

  gspid_divider #(
    .DVD_W (SUM_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dvd_mag),
    .divisor_i  (div_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  // Clamp the quotient and restore the sign
  logic [STEP_W-1:0]        step_mag;
  logic signed [STEP_W-1:0] step_d;
  assign step_mag = (quot > SUM_W'(STEP_LIMIT)) ? STEP_W'(STEP_LIMIT) : quot[STEP_W-1:0];
  assign step_d   = acc_q[SUM_W-1] ? STEP_W'(-step_mag) : STEP_W'(step_mag);

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || result_o.ready);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && item_i.cmd == CMD_STEP) state_d = ST_BAND;
      ST_BAND:  state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MAC;
      ST_MAC:   if (term_q == TERM_D) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state and loop history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_P;
      e1_q        <= '0;
      e2_q        <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && item_i.cmd == CMD_CLEAR) begin
        e1_q    <= '0;
        integ_q <= '0;
      end
      if (state_q == ST_INTEG && legacy_q) begin
        integ_q <= integ_d;
      end
      if (state_q == ST_INTEG) begin
        term_q <= TERM_P;
      end else if (state_q == ST_MAC) begin
        term_q <= term_q + TERM_W'(1);
      end
      // Shift the error history after the last term; the second tap only in the new law
      if (state_q == ST_MAC && term_q == TERM_D) begin
        e1_q <= e_q;
        if (!legacy_q) begin
          e2_q <= e1_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q     <= e_new;
      ms_gt_q <= (item_i.measured > MS_MIN);
    end
    if (state_q == ST_BAND) begin
      band_q <= band_d;
    end
    if (state_q == ST_INTEG) begin
      acc_q <= '0;
    end else if (state_q == ST_MAC) begin
      acc_q <= acc_d;
    end
    if (out_load) begin
      out_step_q <= step_d;
      out_band_q <= band_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.drive_step = out_step_q;
  assign result_o.gain_band  = out_band_q;

`ifndef SYNTH
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= ILIM_CHK) && (integ_q >= -ILIM_CHK))
    else $error("legacy integral outside its saturation limits");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.drive_step <= SLIM) && (result_o.drive_step >= -SLIM)))
    else $error("drive step outside clamp range");

  a_band_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.gain_band != 2'd3))
    else $error("unused gain band code on result");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished while sequencer not waiting");

  a_ready_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_start_next_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |=> (div_stat.busy && state_q == ST_DIV))
    else $error("divider did not start on request");
`endif

endmodule
